FILE: sv/tdq_pkg.sv
// Shared types and constants for the sorted timer queue.
// No dependencies; imported by every module of the block.
package tdq_pkg;

  localparam logic [29:0] NSEC_PER_SEC = 30'd1000000000;
  localparam logic [29:0] NSEC_MAX     = 30'd999999999;
  localparam logic [47:0] SEC_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam int          DIV_BITS     = 63;
  localparam int          QUOT_W       = 34;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_FIRE   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_STALE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         timer_id;
    logic [47:0]        base_sec;
    logic [29:0]        base_nsec;
    logic signed [63:0] delay_ns;
  } tdq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired_valid;
    logic [3:0]  fired_id;
    logic        armed_valid;
    logic [3:0]  armed_id;
    logic [47:0] armed_sec;
    logic [29:0] armed_nsec;
    logic        arm_changed;
  } tdq_rsp_t;

endpackage

FILE: sv/tdq_div.sv
// Divider of a positive delay by one second in nanoseconds.
// Depends on tdq_pkg; long division in 11-bit digits by reciprocal multiply.
module tdq_div
  import tdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIV_BITS-1:0]   dividend,
  output logic                  done,
  output logic [QUOT_W-1:0]     quot,
  output logic [29:0]           rem
);

  // 10^9 = 2^9 * 5^9: the low 9 bits go straight into the remainder, the upper
  // 54 bits are divided by 5^9 one 11-bit digit at a time, MSB first.
  localparam logic [20:0] DIV_ODD = 21'd1953125;
  localparam logic [32:0] RECIP   = 33'd4611686019;  // ceil(2^53 / 5^9), exact for n < 2^32
  localparam int          STEPS   = 5;

  logic [54:0]       xs_r;      // digits still to divide
  logic [8:0]        lo_r;
  logic [20:0]       r_r;       // running remainder, below 5^9
  logic [QUOT_W-1:0] q_r;
  logic [31:0]       n_r;
  logic [10:0]       qd_r;
  logic [2:0]        step_r;
  logic              ph_r;      // 0: estimate digit, 1: update remainder
  logic              run_r;
  logic              done_r;
  logic [31:0]       n_w;
  logic [64:0]       prod;
  logic [31:0]       qd_prod;
  logic [31:0]       r_diff;

  assign n_w     = {r_r, xs_r[54:44]};
  assign prod    = {33'd0, n_w} * {32'd0, RECIP};
  assign qd_prod = {21'd0, qd_r} * {11'd0, DIV_ODD};
  assign r_diff  = n_r - qd_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      step_r <= '0;
    end else if (run_r) begin
      ph_r   <= !ph_r;
      run_r  <= !(ph_r && (step_r == 3'(STEPS - 1)));
      done_r <= ph_r && (step_r == 3'(STEPS - 1));
      if (ph_r) begin
        step_r <= step_r + 3'd1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs_r <= {1'b0, dividend[DIV_BITS-1:9]};
      lo_r <= dividend[8:0];
      r_r  <= '0;
      q_r  <= '0;
    end else if (run_r) begin
      if (!ph_r) begin
        n_r  <= n_w;
        qd_r <= prod[63:53];
      end else begin
        r_r  <= r_diff[20:0];
        q_r  <= {q_r[QUOT_W-12:0], qd_r};
        xs_r <= {xs_r[43:0], 11'd0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = {r_r, lo_r};

endmodule

FILE: sv/timer_deadline_queue_core.sv
// Sorted timer queue: earliest-deadline-first list with one armed deadline.
// Depends on tdq_pkg and tdq_div; order list and deadlines live in local memories.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_req  (tdq_req_t)
//   out_    | output    | out_valid/out_stall| out_rsp (tdq_rsp_t)
//
// One request at a time. Add: division and summing when the delay is positive, then
// carry/saturate, then S_INS_RD, S_INS_DRD and S_INS_CMP per entry in the backward
// insert scan, one more S_INS_RD at the head. Cancel and fire: S_RM_RD and S_RM_CHK
// per position scanned plus a final S_RM_RD; a stale firing stops after the head.
// Every request ends with a head read (no S_HD_DRD if the queue ends empty) and the
// output register. Synchronous active-low reset empties the queue; memories need no
// clearing. A stalled output holds its result; a new request is taken while it waits.
module timer_deadline_queue_core
  import tdq_pkg::*;
#(
  parameter int NUM_TIMERS = 16
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tdq_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output tdq_rsp_t out_rsp
);

  localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;  // position / slot index
  localparam int CW = $clog2(NUM_TIMERS + 1);                     // fill count

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DIV     = 11'b00000000010,
    S_CALC    = 11'b00000000100,
    S_FIX     = 11'b00000001000,
    S_INS_RD  = 11'b00000010000,
    S_INS_DRD = 11'b00000100000,
    S_INS_CMP = 11'b00001000000,
    S_RM_RD   = 11'b00010000000,
    S_RM_CHK  = 11'b00100000000,
    S_HD_RD   = 11'b01000000000,
    S_HD_DRD  = 11'b10000000000
  } state_t;

  // memories: position -> slot, slot -> {sec, nsec}
  logic [PW-1:0] ord_mem [NUM_TIMERS];
  logic [77:0]   dl_mem  [NUM_TIMERS];

  state_t          state_r;
  logic            out_pend_r;     // head read done, result waiting for output register
  tdq_req_t        req_r;
  status_t         status_r;
  logic            fired_r;
  logic [PW-1:0]   fired_id_r;
  logic            found_r;
  logic            expire_r;
  logic            pos_r;
  logic [CW-1:0]   idx_r;
  logic [CW-1:0]   cnt_r;
  logic [NUM_TIMERS-1:0] queued_r;
  logic            armed_flag_r;
  logic [PW-1:0]   armed_slot_r;
  logic            changed_r;
  logic [48:0]     key_sec_r;
  logic [30:0]     key_ns_r;
  logic [77:0]     new_key_r;
  logic [PW-1:0]   elem_r;
  logic [PW-1:0]   ord_q;
  logic [77:0]     dl_q;
  logic            out_valid_r;
  tdq_rsp_t        out_rsp_r;

  logic            in_take;
  logic [PW-1:0]   in_slot;
  logic            in_id_ok;
  logic            in_pos;
  logic [PW-1:0]   id_slot;
  logic [CW-1:0]   idx_m1;

  logic            div_start;
  logic            div_done;
  logic [QUOT_W-1:0] div_quot;
  logic [29:0]     div_rem;

  logic            ord_re;
  logic [PW-1:0]   ord_raddr;
  logic            ord_we;
  logic [PW-1:0]   ord_waddr;
  logic [PW-1:0]   ord_wdata;

  logic            carry;
  logic [48:0]     sec_fix;
  logic [30:0]     ns_fix;
  logic [77:0]     fix_key;
  logic            out_free;

  assign in_stall = (state_r != S_IDLE) || out_pend_r;
  assign in_take  = in_valid && !in_stall;
  assign in_slot  = PW'(in_req.timer_id);
  assign in_id_ok = 32'(in_req.timer_id) < NUM_TIMERS;
  assign in_pos   = !in_req.delay_ns[63] && (in_req.delay_ns != '0);
  assign id_slot  = PW'(req_r.timer_id);
  assign idx_m1   = idx_r - CW'(1);
  assign out_free = !out_valid_r || !out_stall;

  assign div_start = in_take && (in_req.command == CMD_ADD) && in_id_ok
                     && !queued_r[in_slot] && (32'(cnt_r) < NUM_TIMERS) && in_pos;

  tdq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_req.delay_ns[62:0]),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // for a positive delay, carry once into seconds, then saturate on seconds overflow
  always_comb begin
    carry   = pos_r && (key_ns_r >= {1'b0, NSEC_PER_SEC});
    sec_fix = key_sec_r + 49'(carry);
    ns_fix  = carry ? key_ns_r - {1'b0, NSEC_PER_SEC} : key_ns_r;
    if (pos_r && sec_fix[48]) begin
      fix_key = {SEC_MAX, NSEC_MAX};
    end else begin
      fix_key = {sec_fix[47:0], ns_fix[29:0]};
    end
  end

  // order memory port control
  always_comb begin
    ord_re    = 1'b0;
    ord_raddr = '0;
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = id_slot;
    unique case (state_r)
      S_INS_RD: begin
        if (idx_r == '0) begin
          ord_we = 1'b1;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = idx_m1[PW-1:0];
        end
      end
      S_INS_CMP: begin
        ord_we    = 1'b1;
        ord_waddr = idx_r[PW-1:0];
        ord_wdata = (new_key_r < dl_q) ? elem_r : id_slot;
      end
      S_RM_RD: begin
        ord_re    = (idx_r != cnt_r);
        ord_raddr = idx_r[PW-1:0];
      end
      S_RM_CHK: begin
        ord_we    = found_r;
        ord_waddr = idx_m1[PW-1:0];
        ord_wdata = ord_q;
      end
      S_HD_RD: ord_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_q <= ord_mem[ord_raddr];
    end
    if (state_r == S_FIX) begin
      dl_mem[id_slot] <= fix_key;
    end
    if (state_r == S_INS_DRD || state_r == S_HD_DRD) begin
      dl_q <= dl_mem[ord_q];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_pend_r   <= 1'b0;
      cnt_r        <= '0;
      queued_r     <= '0;
      armed_flag_r <= 1'b0;
      armed_slot_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_pend_r && out_free) begin
        out_valid_r <= 1'b1;
        out_pend_r  <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            unique case (in_req.command)
              CMD_ADD: begin
                if (!in_id_ok || queued_r[in_slot] || (32'(cnt_r) >= NUM_TIMERS)) begin
                  state_r <= S_HD_RD;
                end else if (in_pos) begin
                  state_r <= S_DIV;
                end else begin
                  state_r <= S_FIX;
                end
              end
              CMD_CANCEL: begin
                if (in_id_ok && queued_r[in_slot]) begin
                  queued_r[in_slot] <= 1'b0;
                  state_r           <= S_RM_RD;
                end else begin
                  state_r <= S_HD_RD;
                end
              end
              CMD_FIRE: state_r <= (cnt_r == '0) ? S_HD_RD : S_RM_RD;
              default:  state_r <= S_HD_RD;
            endcase
          end
        end
        S_DIV:  if (div_done) state_r <= S_CALC;
        S_CALC: state_r <= S_FIX;
        S_FIX: begin
          queued_r[id_slot] <= 1'b1;
          state_r           <= S_INS_RD;
        end
        S_INS_RD: begin
          if (idx_r == '0) begin
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_HD_RD;
          end else begin
            state_r <= S_INS_DRD;
          end
        end
        S_INS_DRD: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          if (new_key_r < dl_q) begin
            state_r <= S_INS_RD;
          end else begin
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_HD_RD;
          end
        end
        S_RM_RD: begin
          if (idx_r == cnt_r) begin
            if (found_r) cnt_r <= cnt_r - CW'(1);
            state_r <= S_HD_RD;
          end else begin
            state_r <= S_RM_CHK;
          end
        end
        S_RM_CHK: begin
          if (!found_r && expire_r && !(armed_flag_r && (ord_q == armed_slot_r))) begin
            state_r <= S_HD_RD;   // stale firing, list untouched
          end else begin
            state_r <= S_RM_RD;
            if (!found_r && expire_r) begin
              queued_r[ord_q] <= 1'b0;
            end
          end
        end
        S_HD_RD: begin
          if (cnt_r == '0) begin
            armed_flag_r <= 1'b0;
            armed_slot_r <= '0;
            out_pend_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_HD_DRD;
          end
        end
        S_HD_DRD: begin
          armed_flag_r <= 1'b1;
          armed_slot_r <= ord_q;
          out_pend_r   <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // request payload and scan registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          req_r      <= in_req;
          fired_r    <= 1'b0;
          fired_id_r <= '0;
          found_r    <= 1'b0;
          expire_r   <= (in_req.command == CMD_FIRE);
          idx_r      <= '0;
          pos_r      <= in_pos;
          key_sec_r  <= {1'b0, in_req.base_sec};
          key_ns_r   <= {1'b0, in_req.base_nsec};
          if (in_req.command == CMD_ADD &&
              (!in_id_ok || queued_r[in_slot] || (32'(cnt_r) >= NUM_TIMERS))) begin
            status_r <= ST_BUSY;
          end else if (in_req.command == CMD_FIRE && cnt_r == '0) begin
            status_r <= ST_EMPTY;
          end else begin
            status_r <= ST_OK;
          end
        end
      end
      S_CALC: begin
        key_sec_r <= key_sec_r + 49'(div_quot);
        key_ns_r  <= key_ns_r + 31'(div_rem);
      end
      S_FIX: begin
        new_key_r <= fix_key;
        idx_r     <= cnt_r;
      end
      S_INS_DRD: elem_r <= ord_q;
      S_INS_CMP: idx_r  <= idx_m1;
      S_RM_CHK: begin
        idx_r <= idx_r + CW'(1);
        if (!found_r) begin
          if (expire_r) begin
            if (armed_flag_r && (ord_q == armed_slot_r)) begin
              found_r    <= 1'b1;
              fired_r    <= 1'b1;
              fired_id_r <= ord_q;
            end else begin
              status_r <= ST_STALE;
            end
          end else if (ord_q == id_slot) begin
            found_r <= 1'b1;
          end
        end
      end
      S_HD_RD: changed_r <= armed_flag_r && (cnt_r == '0);
      S_HD_DRD: changed_r <= !armed_flag_r || (ord_q != armed_slot_r);
      default: ;
    endcase
  end

  // output register, loaded after the head read once the output is free
  always_ff @(posedge clk) begin
    if (out_pend_r && out_free) begin
      out_rsp_r.status      <= status_r;
      out_rsp_r.fired_valid <= fired_r;
      out_rsp_r.fired_id    <= 4'(fired_id_r);
      out_rsp_r.armed_valid <= armed_flag_r;
      out_rsp_r.armed_id    <= armed_flag_r ? 4'(armed_slot_r) : 4'd0;
      out_rsp_r.armed_sec   <= armed_flag_r ? dl_q[77:30] : 48'd0;
      out_rsp_r.armed_nsec  <= armed_flag_r ? dl_q[29:0] : 30'd0;
      out_rsp_r.arm_changed <= changed_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: sv/tdq_checker.sv
// Port-level checks for the sorted timer queue, bound to its top level.
// Depends on tdq_pkg and timer_deadline_queue_core.
module tdq_checker
  import tdq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input tdq_req_t in_req,
  input logic     out_valid,
  input logic     out_stall,
  input tdq_rsp_t out_rsp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.fired_valid |-> out_rsp.status == ST_OK)
    else $error("fired timer with error status");

  a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.armed_valid |->
      out_rsp.armed_id == 4'd0 && out_rsp.armed_sec == 48'd0 && out_rsp.armed_nsec == 30'd0)
    else $error("disarmed result carries a deadline");

  a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == ST_EMPTY |->
      !out_rsp.armed_valid && !out_rsp.arm_changed && !out_rsp.fired_valid)
    else $error("empty firing changed the armed state");

endmodule

bind timer_deadline_queue_core tdq_checker u_tdq_checker (.*);
